>>> rtl/oisoe_pkg.sv
package oisoe_pkg;

  // Set geometry.
  localparam int DEPTH    = 16;
  localparam int ID_BITS  = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int PORT_ID_W = 16;
  localparam int OCC_W    = 5;

  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PORT_ID_W-1:0] port_id_t;
  typedef logic [OCC_W-1:0]     occ_t;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_INSERT        = 2'd0,
    KIND_REMOVE        = 2'd1,
    KIND_REMOVE_OLDEST = 2'd2,
    KIND_QUERY         = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Control that the top level broadcasts to every cell.
  typedef struct packed {
    logic shift_ins;
    logic shift_rem;
    logic pick_tail;
    id_t  id;
  } chain_ctrl_t;

  // What the end of the chain reports back.
  typedef struct packed {
    logic found;
    id_t  picked;
  } chain_stat_t;

  // Port identifier to internal width: truncate or zero extend.
  function automatic id_t to_id(port_id_t x);
    id_t r;
    for (int b = 0; b < ID_BITS; b++) begin
      r[b] = (b < PORT_ID_W) ? x[b] : 1'b0;
    end
    return r;
  endfunction

  // Internal identifier to port width: truncate or zero extend.
  function automatic port_id_t from_id(id_t x);
    port_id_t r;
    for (int b = 0; b < PORT_ID_W; b++) begin
      r[b] = (b < ID_BITS) ? x[b] : 1'b0;
    end
    return r;
  endfunction

  // Entry count to occupancy port width.
  function automatic occ_t to_occ(cnt_t x);
    occ_t r;
    for (int b = 0; b < OCC_W; b++) begin
      r[b] = (b < CNT_W) ? x[b] : 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/oisoe_cell.sv
module oisoe_cell (
  input  logic                     clk,
  input  oisoe_pkg::chain_ctrl_t   ctrl,
  input  oisoe_pkg::id_t           left_entry,
  input  oisoe_pkg::id_t           right_entry,
  input  logic                     valid,
  input  logic                     tail,
  input  logic                     hit_in,
  input  oisoe_pkg::id_t           pick_in,
  output oisoe_pkg::id_t           entry,
  output logic                     hit_out,
  output oisoe_pkg::id_t           pick_out
);
  import oisoe_pkg::*;

  logic match;
  logic sel;

  // Compare the held identifier and extend the prefix of hits.
  assign match   = valid && (entry == ctrl.id);
  assign hit_out = hit_in | match;

  // Hand the selected entry down the chain; ids are unique, so at most one cell selects.
  assign sel      = ctrl.pick_tail ? tail : match;
  assign pick_out = pick_in | (sel ? entry : '0);

  // Insert moves everything one place older; remove closes the gap from the hit onward.
  always_ff @(posedge clk) begin
    if (ctrl.shift_ins) begin
      entry <= left_entry;
    end else if (ctrl.shift_rem && hit_out) begin
      entry <= right_entry;
    end
  end

endmodule

>>> rtl/oisoe_chain.sv
module oisoe_chain (
  input  logic                     clk,
  input  oisoe_pkg::chain_ctrl_t   ctrl,
  input  oisoe_pkg::cnt_t          count,
  output oisoe_pkg::chain_stat_t   stat
);
  import oisoe_pkg::*;

  id_t  entry [DEPTH];
  logic hit   [DEPTH+1];
  id_t  pick  [DEPTH+1];
  logic valid [DEPTH];
  logic tail  [DEPTH];

  assign hit[0]  = 1'b0;
  assign pick[0] = '0;

  // Row of cells, newest at index 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    id_t left_e;
    id_t right_e;

    assign valid[i] = count > cnt_t'(i);
    assign tail[i]  = count == cnt_t'(i + 1);

    if (i == 0) begin : g_head
      assign left_e = ctrl.id;
    end else begin : g_mid
      assign left_e = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = entry[i];
    end else begin : g_inner
      assign right_e = entry[i+1];
    end

    oisoe_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .left_entry  (left_e),
      .right_entry (right_e),
      .valid       (valid[i]),
      .tail        (tail[i]),
      .hit_in      (hit[i]),
      .pick_in     (pick[i]),
      .entry       (entry[i]),
      .hit_out     (hit[i+1]),
      .pick_out    (pick[i+1])
    );
  end

  assign stat.found  = hit[DEPTH];
  assign stat.picked = pick[DEPTH];

endmodule

>>> rtl/ordered_id_set_oldest_evict_unit.sv
// Channel   Handshake             Payload
// request   in_valid / in_ready   kind, item_id
// result    out_valid / out_ready status, present, removed_id, occupancy
//
// Each request is handled in one pass: all cells compare and shift in the same edge,
// and the result is captured in an output register at the edge that accepts it.
// A new request is taken whenever the output register is empty or being drained,
// so with out_ready high one request is taken every cycle.
// Reset clears the entry count and the output valid; entries need no clearing.
// A stalled result holds the output register and in_ready stays low.
module ordered_id_set_oldest_evict_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind,
  input  oisoe_pkg::port_id_t        item_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic                       present,
  output oisoe_pkg::port_id_t        removed_id,
  output oisoe_pkg::occ_t            occupancy
);
  import oisoe_pkg::*;

  cnt_t        count;
  cnt_t        count_next;
  chain_ctrl_t ctrl;
  chain_stat_t stat;
  kind_t       req_kind;
  logic        accept;
  logic        full;
  logic        empty;
  status_t     st_next;
  logic        present_next;
  id_t         removed_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign req_kind = kind_t'(kind);
  assign full     = count == cnt_t'(DEPTH);
  assign empty    = count == '0;

  oisoe_chain u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .count (count),
    .stat  (stat)
  );

  // Decode the request against the chain's hit report.
  always_comb begin
    ctrl.shift_ins = 1'b0;
    ctrl.shift_rem = 1'b0;
    ctrl.pick_tail = 1'b0;
    ctrl.id        = to_id(item_id);
    st_next        = ST_DONE;
    present_next   = 1'b0;
    removed_next   = '0;
    count_next     = count;
    unique case (req_kind)
      KIND_INSERT: begin
        if (stat.found) begin
          st_next      = ST_DUPLICATE;
          present_next = 1'b1;
        end else if (full) begin
          st_next = ST_FULL;
        end else begin
          ctrl.shift_ins = accept;
          count_next     = count + cnt_t'(1);
        end
      end
      KIND_REMOVE: begin
        if (stat.found) begin
          present_next   = 1'b1;
          removed_next   = stat.picked;
          ctrl.shift_rem = accept;
          count_next     = count - cnt_t'(1);
        end else begin
          st_next = ST_NOT_FOUND;
        end
      end
      KIND_REMOVE_OLDEST: begin
        ctrl.pick_tail = 1'b1;
        if (empty) begin
          st_next = ST_NOT_FOUND;
        end else begin
          present_next = 1'b1;
          removed_next = stat.picked;
          count_next   = count - cnt_t'(1);
        end
      end
      KIND_QUERY: begin
        if (stat.found) begin
          present_next = 1'b1;
        end else begin
          st_next = ST_NOT_FOUND;
        end
      end
      default: begin
        st_next = ST_NOT_FOUND;
      end
    endcase
  end

  // Control state: entry count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= st_next;
      present    <= present_next;
      removed_id <= from_id(removed_next);
      occupancy  <= to_occ(count_next);
    end
  end

endmodule
